FILE: rtl/mgga_pkg.sv
// ============================================================================
// mgga_pkg
// Shared constants, heap entry types, RAM request bundle and sequencer states
// for the min-gap group allocator.
// ============================================================================
package mgga_pkg;

    localparam int MAX_GROUPS = 256;
    localparam int VAL_W      = 31;
    localparam int GRP_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CNT_W      = $clog2(MAX_GROUPS + 1);
    localparam int POS_W      = CNT_W + 1;
    localparam int IDX_W      = 8;
    localparam int TOT_W      = 9;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [GRP_W-1:0] grp;
    } entry_t;

    typedef struct packed {
        logic [VAL_W:0]   val;
        logic [GRP_W-1:0] grp;
    } key_t;

    typedef struct packed {
        logic             re;
        logic [GRP_W-1:0] raddr_a;
        logic [GRP_W-1:0] raddr_b;
        logic             we;
        logic [GRP_W-1:0] waddr;
        entry_t           wdata;
    } ram_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_DN_RD,
        ST_DN_PICK,
        ST_DN_SWAP,
        ST_UP_RD,
        ST_UP_SWAP
    } state_t;

    function automatic key_t to_key(entry_t e);
        key_t k;
        k.val = {1'b0, e.val};
        k.grp = e.grp;
        return k;
    endfunction

endpackage

FILE: rtl/mgga_key_cmp.sv
// ============================================================================
// mgga_key_cmp
// Shared key comparator: (lhs.val + bias, lhs.grp) < (rhs.val, rhs.grp).
// Serves the join test and every heap compare.
// ============================================================================
module mgga_key_cmp (
    input  mgga_pkg::key_t                   lhs,
    input  mgga_pkg::key_t                   rhs,
    input  logic [mgga_pkg::VAL_W-1:0]       bias,
    output logic                             lt
);
    import mgga_pkg::*;

    key_t lhs_biased;

    always_comb
    begin
        lhs_biased     = lhs;
        lhs_biased.val = lhs.val + (VAL_W + 1)'(bias);
        lt             = lhs_biased < rhs;
    end

endmodule

FILE: rtl/mgga_heap_ram.sv
// ============================================================================
// mgga_heap_ram
// Heap storage: one write port, two read ports with registered read data.
// ============================================================================
module mgga_heap_ram (
    input  logic               clk,
    input  mgga_pkg::ram_req_t req,
    output mgga_pkg::entry_t   rd_a,
    output mgga_pkg::entry_t   rd_b
);
    import mgga_pkg::*;

    entry_t heap_mem [MAX_GROUPS];
    entry_t rd_a_reg;
    entry_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            heap_mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_a_reg <= heap_mem[req.raddr_a];
            rd_b_reg <= heap_mem[req.raddr_b];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

FILE: rtl/min_gap_group_allocator.sv
// ============================================================================
// min_gap_group_allocator
// Greedy interval partitioning: assigns each value to the open group with the
// smallest last value when the gap allows, else opens a new group or overflows.
// ============================================================================
// Open groups live in a binary min-heap keyed by (last value, group number),
// held in a two-read, one-write RAM and walked by a small sequencer around a
// single key comparator. One item is taken at a time; item_stall is high
// while it is processed. The result beat is registered from the root
// decision, which waits while an earlier beat is held by result_stall; the
// heap update then continues. A join replaces the heap root and sifts it
// down, each level reading both children, picking the smaller and swapping;
// opening a group sifts the new entry up, each level reading the parent and
// swapping; an overflow returns straight to idle. min_gap may be written
// whenever the block is idle.
module min_gap_group_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [mgga_pkg::VAL_W-1:0] cfg_wr_data,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [mgga_pkg::VAL_W-1:0] item_value,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [mgga_pkg::IDX_W-1:0] group_index,
    output logic                       opened_new,
    output logic                       overflow,
    output logic [mgga_pkg::TOT_W-1:0] group_total
);
    import mgga_pkg::*;

    state_t             state_reg,     state_next;
    logic [VAL_W-1:0]   gap_reg,       gap_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic [VAL_W-1:0]   x_reg,         x_next;
    entry_t             elem_reg,      elem_next;
    entry_t             child_reg,     child_next;
    logic [GRP_W-1:0]   pos_reg,       pos_next;
    logic [GRP_W-1:0]   child_pos_reg, child_pos_next;
    logic               res_valid_reg, res_valid_next;
    logic [IDX_W-1:0]   res_index_reg, res_index_next;
    logic               res_opened_reg, res_opened_next;
    logic               res_ovf_reg,   res_ovf_next;
    logic [TOT_W-1:0]   res_total_reg, res_total_next;

    ram_req_t           ram_req;
    entry_t             rd_a;
    entry_t             rd_b;
    key_t               cmp_lhs;
    key_t               cmp_rhs;
    logic [VAL_W-1:0]   cmp_bias;
    logic               cmp_lt;

    logic [POS_W-1:0]   left_pos;
    logic [POS_W-1:0]   right_pos;
    logic               left_ok;
    logic               right_ok;
    logic [GRP_W-1:0]   parent_pos;
    logic               slot_free;
    logic               is_join;
    logic               can_open;
    logic [CNT_W-1:0]   count_inc;

    mgga_heap_ram u_ram (
        .clk  (clk),
        .req  (ram_req),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    mgga_key_cmp u_cmp (
        .lhs  (cmp_lhs),
        .rhs  (cmp_rhs),
        .bias (cmp_bias),
        .lt   (cmp_lt)
    );

    assign left_pos   = POS_W'({pos_reg, 1'b1});
    assign right_pos  = left_pos + POS_W'(1);
    assign left_ok    = left_pos < POS_W'(count_reg);
    assign right_ok   = right_pos < POS_W'(count_reg);
    assign parent_pos = (pos_reg - GRP_W'(1)) >> 1;
    assign slot_free  = !res_valid_reg || !result_stall;
    assign is_join    = (count_reg != '0) && cmp_lt;
    assign can_open   = count_reg < CNT_W'(MAX_GROUPS);
    assign count_inc  = count_reg + CNT_W'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (slot_free)
                begin
                    if (is_join)
                    begin
                        state_next = ST_DN_RD;
                    end
                    else if (can_open)
                    begin
                        state_next = ST_UP_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DN_RD:
            begin
                state_next = ST_DN_PICK;
            end
            ST_DN_PICK:
            begin
                state_next = left_ok ? ST_DN_SWAP : ST_IDLE;
            end
            ST_DN_SWAP:
            begin
                state_next = cmp_lt ? ST_DN_RD : ST_IDLE;
            end
            ST_UP_RD:
            begin
                state_next = (pos_reg == '0) ? ST_IDLE : ST_UP_SWAP;
            end
            ST_UP_SWAP:
            begin
                state_next = cmp_lt ? ST_UP_RD : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM requests and comparator operands
    always_comb
    begin
        gap_next        = cfg_wr_en ? cfg_wr_data : gap_reg;
        count_next      = count_reg;
        x_next          = x_reg;
        elem_next       = elem_reg;
        child_next      = child_reg;
        pos_next        = pos_reg;
        child_pos_next  = child_pos_reg;
        res_valid_next  = res_valid_reg && result_stall;
        res_index_next  = res_index_reg;
        res_opened_next = res_opened_reg;
        res_ovf_next    = res_ovf_reg;
        res_total_next  = res_total_reg;
        ram_req         = '0;
        cmp_lhs         = to_key(rd_a);
        cmp_rhs         = to_key(rd_b);
        cmp_bias        = '0;
        item_stall      = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                ram_req.re = 1'b1;
                if (item_valid)
                begin
                    x_next = item_value;
                end
            end
            ST_ROOT:
            begin
                cmp_lhs     = to_key(rd_a);
                cmp_rhs.val = {1'b0, x_reg};
                cmp_rhs.grp = rd_a.grp;
                cmp_bias    = gap_reg;
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    if (is_join)
                    begin
                        elem_next.val   = x_reg;
                        elem_next.grp   = rd_a.grp;
                        pos_next        = '0;
                        res_index_next  = IDX_W'(rd_a.grp);
                        res_opened_next = 1'b0;
                        res_ovf_next    = 1'b0;
                        res_total_next  = TOT_W'(count_reg);
                    end
                    else if (can_open)
                    begin
                        elem_next.val   = x_reg;
                        elem_next.grp   = count_reg[GRP_W-1:0];
                        pos_next        = count_reg[GRP_W-1:0];
                        count_next      = count_inc;
                        res_index_next  = IDX_W'(count_reg);
                        res_opened_next = 1'b1;
                        res_ovf_next    = 1'b0;
                        res_total_next  = TOT_W'(count_inc);
                    end
                    else
                    begin
                        res_index_next  = '0;
                        res_opened_next = 1'b0;
                        res_ovf_next    = 1'b1;
                        res_total_next  = TOT_W'(count_reg);
                    end
                end
            end
            ST_DN_RD:
            begin
                ram_req.re      = 1'b1;
                ram_req.raddr_a = left_pos[GRP_W-1:0];
                ram_req.raddr_b = right_pos[GRP_W-1:0];
            end
            ST_DN_PICK:
            begin
                cmp_lhs = to_key(rd_b);
                cmp_rhs = to_key(rd_a);
                if (!left_ok)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pos_reg;
                    ram_req.wdata = elem_reg;
                end
                else if (right_ok && cmp_lt)
                begin
                    child_next     = rd_b;
                    child_pos_next = right_pos[GRP_W-1:0];
                end
                else
                begin
                    child_next     = rd_a;
                    child_pos_next = left_pos[GRP_W-1:0];
                end
            end
            ST_DN_SWAP:
            begin
                cmp_lhs       = to_key(child_reg);
                cmp_rhs       = to_key(elem_reg);
                ram_req.we    = 1'b1;
                ram_req.waddr = pos_reg;
                if (cmp_lt)
                begin
                    ram_req.wdata = child_reg;
                    pos_next      = child_pos_reg;
                end
                else
                begin
                    ram_req.wdata = elem_reg;
                end
            end
            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pos_reg;
                    ram_req.wdata = elem_reg;
                end
                else
                begin
                    ram_req.re      = 1'b1;
                    ram_req.raddr_a = parent_pos;
                end
            end
            ST_UP_SWAP:
            begin
                cmp_lhs       = to_key(elem_reg);
                cmp_rhs       = to_key(rd_a);
                ram_req.we    = 1'b1;
                ram_req.waddr = pos_reg;
                if (cmp_lt)
                begin
                    ram_req.wdata = rd_a;
                    pos_next      = parent_pos;
                end
                else
                begin
                    ram_req.wdata = elem_reg;
                end
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gap_reg       <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gap_reg       <= gap_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        elem_reg       <= elem_next;
        child_reg      <= child_next;
        pos_reg        <= pos_next;
        child_pos_reg  <= child_pos_next;
        res_index_reg  <= res_index_next;
        res_opened_reg <= res_opened_next;
        res_ovf_reg    <= res_ovf_next;
        res_total_reg  <= res_total_next;
    end

    assign result_valid = res_valid_reg;
    assign group_index  = res_index_reg;
    assign opened_new   = res_opened_reg;
    assign overflow     = res_ovf_reg;
    assign group_total  = res_total_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_GROUPS))
        else $error("group count above capacity");

    a_result_from_root: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_ROOT))
        else $error("result beat not issued from root decision");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && overflow) |-> (!opened_new && group_total == TOT_W'(MAX_GROUPS)))
        else $error("overflow beat with free groups or opened flag");

    a_open_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT && state_next == ST_UP_RD) |=>
            (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("new group did not advance count");
`endif

endmodule
